>>> rtl/hrbp_pkg.sv
// shared types and codes for the http request byte parser
package hrbp_pkg;

    // result status codes
    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // byte class codes
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI    = 3'd2;
    localparam logic [2:0] CLS_PNAME  = 3'd3;
    localparam logic [2:0] CLS_PVALUE = 3'd4;
    localparam logic [2:0] CLS_HNAME  = 3'd5;
    localparam logic [2:0] CLS_HVALUE = 3'd6;

    // ascii characters the parser looks for
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_QUEST  = 8'h3f;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_UP_P   = 8'h50;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    // one classified word as it waits between front and back
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       is_cntrl;
        logic       is_space;
        logic       is_digit;
        logic       is_alpha;
        logic       is_special;
    } item_t;

endpackage

>>> rtl/hrbp_if.sv
// valid/ready channel interfaces for request bytes and parse results
interface hrbp_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface hrbp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] byte_class;
    logic       token_end;
    logic [7:0] major_version;
    logic [7:0] minor_version;

    modport source (
        output valid, output status, output byte_class, output token_end,
        output major_version, output minor_version, input ready
    );
    modport sink (
        input valid, input status, input byte_class, input token_end,
        input major_version, input minor_version, output ready
    );
endinterface

>>> rtl/http_request_byte_parser.sv
// top level of the http request byte parser
//
// req carries one word per request byte (op = 0) or a restart command
// (op = 1). rsp returns exactly one result word for each request word, in
// order: status (need more, fail, complete), byte class, token end flag and
// the major/minor version numbers accumulated so far.
//
// a word accepted on req is classified and written into a small queue in
// the same cycle; the parser state machine takes it from the queue and its
// result appears on rsp in a register. throughput is one word per cycle
// while rsp is not stalled.
//
// when rsp is stalled the result register holds, the parser stops taking
// words and the queue fills; req.ready drops once QUEUE_DEPTH words wait.
// reset (rst_n low) empties the queue and result register and puts the
// parser at the start of the method with both versions at zero.
module http_request_byte_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    hrbp_req_if.sink    req,
    hrbp_rsp_if.source  rsp
);

    logic            push_valid;
    logic            push_ready;
    hrbp_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop;
    hrbp_pkg::item_t pop_item;

    hrbp_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    hrbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    hrbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_pop   (pop),
        .item       (pop_item),
        .rsp        (rsp)
    );

endmodule

>>> rtl/hrbp_front.sv
// front end: takes request words and tags each byte with its character classes
module hrbp_front (
    hrbp_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output hrbp_pkg::item_t push_item
);

    logic [7:0] c;

    assign c          = req.data_byte;
    assign req.ready  = push_ready;
    assign push_valid = req.valid;

    always_comb
    begin
        push_item.op        = req.op;
        push_item.data_byte = c;
        push_item.is_cntrl  = (c < hrbp_pkg::CH_SPACE) || (c == hrbp_pkg::CH_DEL);
        push_item.is_space  = (c == hrbp_pkg::CH_SPACE)
                              || ((c >= hrbp_pkg::CH_TAB) && (c <= hrbp_pkg::CH_CR));
        push_item.is_digit  = (c >= hrbp_pkg::CH_ZERO) && (c <= hrbp_pkg::CH_NINE);
        push_item.is_alpha  = ((c >= hrbp_pkg::CH_LO_A) && (c <= hrbp_pkg::CH_LO_Z))
                              || ((c >= hrbp_pkg::CH_UP_A) && (c <= hrbp_pkg::CH_UP_Z));
        push_item.is_special = (c == hrbp_pkg::CH_LPAREN) || (c == hrbp_pkg::CH_RPAREN)
                              || (c == hrbp_pkg::CH_LT) || (c == hrbp_pkg::CH_GT)
                              || (c == hrbp_pkg::CH_AT) || (c == hrbp_pkg::CH_COMMA)
                              || (c == hrbp_pkg::CH_SEMI) || (c == hrbp_pkg::CH_COLON)
                              || (c == hrbp_pkg::CH_BSLASH) || (c == hrbp_pkg::CH_DQUOTE)
                              || (c == hrbp_pkg::CH_SLASH) || (c == hrbp_pkg::CH_LBRACK)
                              || (c == hrbp_pkg::CH_RBRACK) || (c == hrbp_pkg::CH_QUEST)
                              || (c == hrbp_pkg::CH_EQUAL) || (c == hrbp_pkg::CH_LBRACE)
                              || (c == hrbp_pkg::CH_RBRACE) || (c == hrbp_pkg::CH_SPACE)
                              || (c == hrbp_pkg::CH_TAB);
    end

endmodule

>>> rtl/hrbp_queue.sv
// small register queue between the classifier and the parser state machine
module hrbp_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  hrbp_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop,
    output hrbp_pkg::item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hrbp_pkg::item_t entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/hrbp_back.sv
// back end: request parser state machine and registered result word
module hrbp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_pop,
    input  hrbp_pkg::item_t item,
    hrbp_rsp_if.source      rsp
);

    typedef enum logic [4:0] {
        PH_METHOD_BEGIN, PH_METHOD, PH_SPACE_BEFORE_URI, PH_SCHEME,
        PH_SCHEME_SLASH, PH_SCHEME_SLASH2, PH_HOST_BEGIN, PH_HOST,
        PH_HOST_END, PH_HOST_IP, PH_PORT, PH_AFTER_SLASH,
        PH_URI, PH_PARAM_NAME, PH_PARAM_VALUE, PH_VER_H,
        PH_VER_T1, PH_VER_T2, PH_VER_P, PH_VER_SLASH,
        PH_MAJOR_BEGIN, PH_MAJOR, PH_MINOR_BEGIN, PH_MINOR,
        PH_NL1, PH_LINE_BEGIN, PH_LWS, PH_HNAME,
        PH_SPACE_BEFORE_HV, PH_HVALUE, PH_NL2, PH_NL3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] major_reg, major_next;
    logic [7:0] minor_reg, minor_next;
    logic       seen_reg, seen_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic [2:0] class_reg, class_next;
    logic       end_reg, end_next;
    logic [7:0] out_major_reg, out_major_next;
    logic [7:0] out_minor_reg, out_minor_next;

    // step results before the fail / restart override
    phase_t     np;
    logic [1:0] st;
    logic [2:0] cls;
    logic       te;
    logic [7:0] maj;
    logic [7:0] mnr;
    logic       hs;

    logic [7:0] c;
    logic       alnum;
    logic       host_char;
    logic       blank;

    function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] ch);
        logic [11:0] r;
        r = ({4'd0, v} * 12'd10) + {8'd0, ch[3:0]};
        return (r > 12'd255) ? 8'hff : r[7:0];
    endfunction

    assign c         = item.data_byte;
    assign alnum     = item.is_alpha || item.is_digit;
    assign host_char = alnum || (c == hrbp_pkg::CH_DOT) || (c == hrbp_pkg::CH_MINUS);
    assign blank     = (c == hrbp_pkg::CH_SPACE) || (c == hrbp_pkg::CH_TAB);

    assign item_pop = item_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        np  = phase_reg;
        st  = hrbp_pkg::ST_MORE;
        cls = hrbp_pkg::CLS_NONE;
        te  = 1'b0;
        maj = major_reg;
        mnr = minor_reg;
        hs  = seen_reg;
        unique case (phase_reg)
            PH_METHOD_BEGIN:
            begin
                if (item.is_cntrl || item.is_special) st = hrbp_pkg::ST_FAIL;
                else
                begin
                    np  = PH_METHOD;
                    cls = hrbp_pkg::CLS_METHOD;
                end
            end
            PH_METHOD:
            begin
                if (item.is_space)
                begin
                    np = PH_SPACE_BEFORE_URI;
                    te = 1'b1;
                end
                else if (item.is_cntrl || item.is_special) st = hrbp_pkg::ST_FAIL;
                else cls = hrbp_pkg::CLS_METHOD;
            end
            PH_SPACE_BEFORE_URI, PH_SCHEME:
            begin
                // space-before-uri drops into the scheme test for other bytes
                if ((phase_reg == PH_SPACE_BEFORE_URI) && item.is_space)
                begin
                end
                else if ((phase_reg == PH_SPACE_BEFORE_URI) && (c == hrbp_pkg::CH_SLASH))
                begin
                    np  = PH_AFTER_SLASH;
                    cls = hrbp_pkg::CLS_URI;
                end
                else if ((phase_reg == PH_SPACE_BEFORE_URI) && item.is_alpha)
                begin
                    np  = PH_SCHEME;
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (alnum || (c == hrbp_pkg::CH_PLUS) || (c == hrbp_pkg::CH_MINUS)
                         || (c == hrbp_pkg::CH_DOT))
                begin
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (c == hrbp_pkg::CH_COLON)
                begin
                    np  = PH_SCHEME_SLASH;
                    cls = hrbp_pkg::CLS_URI;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_SCHEME_SLASH:
            begin
                if (c == hrbp_pkg::CH_SLASH)
                begin
                    np  = PH_SCHEME_SLASH2;
                    cls = hrbp_pkg::CLS_URI;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_SCHEME_SLASH2:
            begin
                if (c == hrbp_pkg::CH_SLASH)
                begin
                    np  = PH_HOST_BEGIN;
                    cls = hrbp_pkg::CLS_URI;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_HOST_BEGIN, PH_HOST, PH_HOST_END:
            begin
                // host begin falls into host, host falls into host end
                if ((phase_reg != PH_HOST_END) && host_char)
                begin
                    if (phase_reg == PH_HOST_BEGIN) np = PH_HOST;
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (c == hrbp_pkg::CH_COLON)
                begin
                    np  = PH_PORT;
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (c == hrbp_pkg::CH_SLASH)
                begin
                    np  = PH_AFTER_SLASH;
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (c == hrbp_pkg::CH_QUEST)
                begin
                    np = PH_PARAM_NAME;
                    te = 1'b1;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_HOST_IP:
            begin
                if (alnum || (c == hrbp_pkg::CH_COLON) || (c == hrbp_pkg::CH_DOT))
                begin
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (c == hrbp_pkg::CH_RBRACK)
                begin
                    np  = PH_HOST_END;
                    cls = hrbp_pkg::CLS_URI;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_PORT:
            begin
                if (item.is_digit) cls = hrbp_pkg::CLS_URI;
                else if (c == hrbp_pkg::CH_SLASH)
                begin
                    np  = PH_AFTER_SLASH;
                    cls = hrbp_pkg::CLS_URI;
                end
                else if (c == hrbp_pkg::CH_QUEST)
                begin
                    np = PH_PARAM_NAME;
                    te = 1'b1;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_AFTER_SLASH, PH_URI:
            begin
                if (item.is_space)
                begin
                    np = PH_VER_H;
                    te = 1'b1;
                end
                else if (item.is_cntrl) st = hrbp_pkg::ST_FAIL;
                else if (c == hrbp_pkg::CH_QUEST)
                begin
                    np = PH_PARAM_NAME;
                    te = 1'b1;
                end
                else cls = hrbp_pkg::CLS_URI;
            end
            PH_PARAM_NAME:
            begin
                if (c == hrbp_pkg::CH_AMP) te = 1'b1;
                else if (item.is_space)
                begin
                    np = PH_VER_H;
                    te = 1'b1;
                end
                else if (c == hrbp_pkg::CH_EQUAL)
                begin
                    np = PH_PARAM_VALUE;
                    te = 1'b1;
                end
                else cls = hrbp_pkg::CLS_PNAME;
            end
            PH_PARAM_VALUE:
            begin
                if (c == hrbp_pkg::CH_AMP)
                begin
                    np = PH_PARAM_NAME;
                    te = 1'b1;
                end
                else if (c == hrbp_pkg::CH_SPACE)
                begin
                    np = PH_VER_H;
                    te = 1'b1;
                end
                else cls = hrbp_pkg::CLS_PVALUE;
            end
            PH_VER_H:
            begin
                if (c == hrbp_pkg::CH_UP_H) np = PH_VER_T1;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_VER_T1:
            begin
                if (c == hrbp_pkg::CH_UP_T) np = PH_VER_T2;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_VER_T2:
            begin
                if (c == hrbp_pkg::CH_UP_T) np = PH_VER_P;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_VER_P:
            begin
                if (c == hrbp_pkg::CH_UP_P) np = PH_VER_SLASH;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_VER_SLASH:
            begin
                if (c == hrbp_pkg::CH_SLASH) np = PH_MAJOR_BEGIN;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_MAJOR_BEGIN:
            begin
                if (item.is_digit)
                begin
                    maj = add_digit(major_reg, c);
                    np  = PH_MAJOR;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_MAJOR:
            begin
                if (c == hrbp_pkg::CH_DOT) np = PH_MINOR_BEGIN;
                else if (item.is_digit) maj = add_digit(major_reg, c);
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_MINOR_BEGIN:
            begin
                if (item.is_digit)
                begin
                    mnr = add_digit(minor_reg, c);
                    np  = PH_MINOR;
                end
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_MINOR:
            begin
                if (c == hrbp_pkg::CH_CR) np = PH_NL1;
                else if (item.is_digit) mnr = add_digit(minor_reg, c);
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_NL1:
            begin
                if (c == hrbp_pkg::CH_LF) np = PH_LINE_BEGIN;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_LINE_BEGIN:
            begin
                if (c == hrbp_pkg::CH_CR) np = PH_NL3;
                else if (seen_reg && blank) np = PH_LWS;
                else if (item.is_cntrl || item.is_special) st = hrbp_pkg::ST_FAIL;
                else
                begin
                    np  = PH_HNAME;
                    cls = hrbp_pkg::CLS_HNAME;
                end
            end
            PH_LWS:
            begin
                if (c == hrbp_pkg::CH_CR)
                begin
                    np = PH_NL2;
                    te = 1'b1;
                end
                else if (blank)
                begin
                end
                else if (item.is_cntrl) st = hrbp_pkg::ST_FAIL;
                else
                begin
                    np  = PH_HVALUE;
                    cls = hrbp_pkg::CLS_HVALUE;
                    hs  = 1'b1;
                end
            end
            PH_HNAME:
            begin
                if (c == hrbp_pkg::CH_COLON)
                begin
                    np = PH_SPACE_BEFORE_HV;
                    te = 1'b1;
                end
                else if (item.is_cntrl || item.is_special) st = hrbp_pkg::ST_FAIL;
                else cls = hrbp_pkg::CLS_HNAME;
            end
            PH_SPACE_BEFORE_HV:
            begin
                if (c == hrbp_pkg::CH_SPACE) np = PH_HVALUE;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_HVALUE:
            begin
                if (c == hrbp_pkg::CH_CR)
                begin
                    np = PH_NL2;
                    te = 1'b1;
                end
                else if (item.is_cntrl) st = hrbp_pkg::ST_FAIL;
                else
                begin
                    cls = hrbp_pkg::CLS_HVALUE;
                    hs  = 1'b1;
                end
            end
            PH_NL2:
            begin
                if (c == hrbp_pkg::CH_LF) np = PH_LINE_BEGIN;
                else st = hrbp_pkg::ST_FAIL;
            end
            PH_NL3:
            begin
                st = (c == hrbp_pkg::CH_LF) ? hrbp_pkg::ST_DONE : hrbp_pkg::ST_FAIL;
            end
            default:
            begin
                st = hrbp_pkg::ST_FAIL;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        class_next     = class_reg;
        end_next       = end_reg;
        out_major_next = out_major_reg;
        out_minor_next = out_minor_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (item_pop)
        begin
            out_valid_next = 1'b1;
            if (item.op)
            begin
                phase_next     = PH_METHOD_BEGIN;
                major_next     = '0;
                minor_next     = '0;
                seen_next      = 1'b0;
                status_next    = hrbp_pkg::ST_MORE;
                class_next     = hrbp_pkg::CLS_NONE;
                end_next       = 1'b0;
                out_major_next = '0;
                out_minor_next = '0;
            end
            else if (st == hrbp_pkg::ST_FAIL)
            begin
                // a failing byte leaves the parse state alone
                status_next    = hrbp_pkg::ST_FAIL;
                class_next     = hrbp_pkg::CLS_NONE;
                end_next       = 1'b0;
                out_major_next = major_reg;
                out_minor_next = minor_reg;
            end
            else
            begin
                phase_next     = np;
                major_next     = maj;
                minor_next     = mnr;
                seen_next      = hs;
                status_next    = st;
                class_next     = cls;
                end_next       = te;
                out_major_next = maj;
                out_minor_next = mnr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD_BEGIN;
            major_reg     <= '0;
            minor_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= hrbp_pkg::ST_MORE;
            class_reg     <= hrbp_pkg::CLS_NONE;
            end_reg       <= 1'b0;
            out_major_reg <= '0;
            out_minor_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            class_reg     <= class_next;
            end_reg       <= end_next;
            out_major_reg <= out_major_next;
            out_minor_reg <= out_minor_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.byte_class    = class_reg;
    assign rsp.token_end     = end_reg;
    assign rsp.major_version = out_major_reg;
    assign rsp.minor_version = out_minor_reg;

endmodule

>>> rtl/hrbp_checker.sv
// port-level checks on the parser results, bound to the top level
module hrbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [2:0] byte_class,
    input logic       token_end,
    input logic [7:0] major_version,
    input logic [7:0] minor_version
);

    // a failing byte carries no class and closes nothing
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == hrbp_pkg::ST_FAIL)
        |-> (byte_class == hrbp_pkg::CLS_NONE) && !token_end)
        else $error("fail result with class or token end");

    // the byte that closes a token is a delimiter and always passes
    a_end_delim: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && token_end
        |-> (byte_class == hrbp_pkg::CLS_NONE) && (status == hrbp_pkg::ST_MORE))
        else $error("token end on a classed or non-passing byte");

    // the final newline is not part of any token
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == hrbp_pkg::ST_DONE)
        |-> (byte_class == hrbp_pkg::CLS_NONE) && !token_end)
        else $error("complete result with class or token end");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready
        |=> rsp_valid && $stable(status) && $stable(byte_class) && $stable(token_end)
            && $stable(major_version) && $stable(minor_version))
        else $error("stalled result word changed");

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .byte_class    (rsp.byte_class),
    .token_end     (rsp.token_end),
    .major_version (rsp.major_version),
    .minor_version (rsp.minor_version)
);

>>> tb/http_request_byte_parser_tb.sv
// self-checking testbench for the http request byte parser
module http_request_byte_parser_tb;
    import hrbp_pkg::*;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [5:0] {
        PH_METHOD_BEGIN, PH_METHOD, PH_SPACE_BEFORE_URI, PH_SCHEME,
        PH_SCHEME_SLASH, PH_SCHEME_SLASH2, PH_HOST_BEGIN, PH_HOST,
        PH_HOST_END, PH_HOST_IP, PH_PORT, PH_AFTER_SLASH,
        PH_URI, PH_PARAM_NAME, PH_PARAM_VALUE, PH_VER_H,
        PH_VER_T1, PH_VER_T2, PH_VER_P, PH_VER_SLASH,
        PH_MAJOR_BEGIN, PH_MAJOR, PH_MINOR_BEGIN, PH_MINOR,
        PH_NL1, PH_LINE_BEGIN, PH_LWS, PH_HNAME,
        PH_SPACE_BEFORE_HV, PH_HVALUE, PH_NL2, PH_NL3
    } phase_t;

    typedef enum {
        K_TOKEN, K_ALPHA, K_SCHEME, K_HOST, K_DIGIT, K_PATH, K_PARAM, K_TEXT
    } char_kind_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_class;
        logic       token_end;
        logic [7:0] major_version;
        logic [7:0] minor_version;
    } parse_result_t;

    logic clk;
    logic rst_n;

    hrbp_req_if req ();
    hrbp_rsp_if rsp ();

    http_request_byte_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // parser state as the testbench tracks it
    phase_t     phase     = PH_METHOD_BEGIN;
    logic [7:0] major_cnt = '0;
    logic [7:0] minor_cnt = '0;
    logic       hdr_seen  = 1'b0;

    parse_result_t pending_results[$];
    int error_count = 0;
    int words_sent  = 0;
    int src_calm    = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_cntrl(logic [7:0] c);
        return c < CH_SPACE || c == CH_DEL;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic bit is_special(logic [7:0] c);
        case (c)
            CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_AT, CH_COMMA, CH_SEMI,
            CH_COLON, CH_BSLASH, CH_DQUOTE, CH_SLASH, CH_LBRACK, CH_RBRACK,
            CH_QUEST, CH_EQUAL, CH_LBRACE, CH_RBRACE, CH_SPACE, CH_TAB:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // decimal accumulate, clamped at 255
    function automatic logic [7:0] add_digit(logic [7:0] v, logic [7:0] c);
        int r;
        r = int'(v) * 10 + int'(c) - int'(CH_ZERO);
        return (r > 255) ? 8'd255 : 8'(r);
    endfunction

    // adds one byte at the tail of a request
    function automatic void append_byte(ref logic [7:0] msg[$], input logic [7:0] c);
        msg.insert(msg.size(), c);
    endfunction

    // works out the result of one word and advances the tracked state
    function automatic parse_result_t predict_parse(logic op, logic [7:0] c);
        parse_result_t r;
        phase_t     np;
        logic [1:0] st;
        logic [2:0] cls;
        logic       tend;
        logic [7:0] maj;
        logic [7:0] mnr;
        logic       hs;
        np   = phase;
        st   = ST_MORE;
        cls  = CLS_NONE;
        tend = 1'b0;
        maj  = major_cnt;
        mnr  = minor_cnt;
        hs   = hdr_seen;
        if (op == OP_RESTART)
        begin
            phase     = PH_METHOD_BEGIN;
            major_cnt = '0;
            minor_cnt = '0;
            hdr_seen  = 1'b0;
            r = '{ST_MORE, CLS_NONE, 1'b0, 8'd0, 8'd0};
            return r;
        end
        case (phase)
            PH_METHOD_BEGIN:
                if (is_cntrl(c) || is_special(c)) st = ST_FAIL;
                else
                begin
                    np = PH_METHOD;
                    cls = CLS_METHOD;
                end
            PH_METHOD:
                if (is_space(c))
                begin
                    np = PH_SPACE_BEFORE_URI;
                    tend = 1'b1;
                end
                else if (is_cntrl(c) || is_special(c)) st = ST_FAIL;
                else cls = CLS_METHOD;
            PH_SPACE_BEFORE_URI, PH_SCHEME:
                // before the uri, bytes that are none of space, slash or letter
                // get the scheme test
                if (phase == PH_SPACE_BEFORE_URI && is_space(c)) ;
                else if (phase == PH_SPACE_BEFORE_URI && c == CH_SLASH)
                begin
                    np = PH_AFTER_SLASH;
                    cls = CLS_URI;
                end
                else if (phase == PH_SPACE_BEFORE_URI && is_alpha(c))
                begin
                    np = PH_SCHEME;
                    cls = CLS_URI;
                end
                else if (is_alnum(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT)
                    cls = CLS_URI;
                else if (c == CH_COLON)
                begin
                    np = PH_SCHEME_SLASH;
                    cls = CLS_URI;
                end
                else st = ST_FAIL;
            PH_SCHEME_SLASH:
                if (c == CH_SLASH)
                begin
                    np = PH_SCHEME_SLASH2;
                    cls = CLS_URI;
                end
                else st = ST_FAIL;
            PH_SCHEME_SLASH2:
                if (c == CH_SLASH)
                begin
                    np = PH_HOST_BEGIN;
                    cls = CLS_URI;
                end
                else st = ST_FAIL;
            PH_HOST_BEGIN, PH_HOST, PH_HOST_END:
            begin
                // host start takes the host test, a non-host byte the host end test
                if (phase == PH_HOST_BEGIN)
                    np = (c == CH_LBRACK) ? PH_HOST_IP : PH_HOST;
                if (phase != PH_HOST_END && (is_alnum(c) || c == CH_DOT || c == CH_MINUS))
                    cls = CLS_URI;
                else if (c == CH_COLON)
                begin
                    np = PH_PORT;
                    cls = CLS_URI;
                end
                else if (c == CH_SLASH)
                begin
                    np = PH_AFTER_SLASH;
                    cls = CLS_URI;
                end
                else if (c == CH_QUEST)
                begin
                    np = PH_PARAM_NAME;
                    tend = 1'b1;
                end
                else st = ST_FAIL;
            end
            PH_HOST_IP:
                if (is_alnum(c) || c == CH_COLON || c == CH_DOT) cls = CLS_URI;
                else if (c == CH_RBRACK)
                begin
                    np = PH_HOST_END;
                    cls = CLS_URI;
                end
                else st = ST_FAIL;
            PH_PORT:
                if (is_digit(c)) cls = CLS_URI;
                else if (c == CH_SLASH)
                begin
                    np = PH_AFTER_SLASH;
                    cls = CLS_URI;
                end
                else if (c == CH_QUEST)
                begin
                    np = PH_PARAM_NAME;
                    tend = 1'b1;
                end
                else st = ST_FAIL;
            PH_AFTER_SLASH, PH_URI:
                if (is_space(c))
                begin
                    np = PH_VER_H;
                    tend = 1'b1;
                end
                else if (is_cntrl(c)) st = ST_FAIL;
                else if (c == CH_QUEST)
                begin
                    np = PH_PARAM_NAME;
                    tend = 1'b1;
                end
                else cls = CLS_URI;
            PH_PARAM_NAME:
                if (c == CH_AMP) tend = 1'b1;
                else if (is_space(c))
                begin
                    np = PH_VER_H;
                    tend = 1'b1;
                end
                else if (c == CH_EQUAL)
                begin
                    np = PH_PARAM_VALUE;
                    tend = 1'b1;
                end
                else cls = CLS_PNAME;
            PH_PARAM_VALUE:
                if (c == CH_AMP)
                begin
                    np = PH_PARAM_NAME;
                    tend = 1'b1;
                end
                else if (c == CH_SPACE)
                begin
                    np = PH_VER_H;
                    tend = 1'b1;
                end
                else cls = CLS_PVALUE;
            PH_VER_H:     if (c == CH_UP_H) np = PH_VER_T1; else st = ST_FAIL;
            PH_VER_T1:    if (c == CH_UP_T) np = PH_VER_T2; else st = ST_FAIL;
            PH_VER_T2:    if (c == CH_UP_T) np = PH_VER_P; else st = ST_FAIL;
            PH_VER_P:     if (c == CH_UP_P) np = PH_VER_SLASH; else st = ST_FAIL;
            PH_VER_SLASH: if (c == CH_SLASH) np = PH_MAJOR_BEGIN; else st = ST_FAIL;
            PH_MAJOR_BEGIN:
                if (is_digit(c))
                begin
                    maj = add_digit(maj, c);
                    np = PH_MAJOR;
                end
                else st = ST_FAIL;
            PH_MAJOR:
                if (c == CH_DOT) np = PH_MINOR_BEGIN;
                else if (is_digit(c)) maj = add_digit(maj, c);
                else st = ST_FAIL;
            PH_MINOR_BEGIN:
                if (is_digit(c))
                begin
                    mnr = add_digit(mnr, c);
                    np = PH_MINOR;
                end
                else st = ST_FAIL;
            PH_MINOR:
                if (c == CH_CR) np = PH_NL1;
                else if (is_digit(c)) mnr = add_digit(mnr, c);
                else st = ST_FAIL;
            PH_NL1:
                if (c == CH_LF) np = PH_LINE_BEGIN; else st = ST_FAIL;
            PH_LINE_BEGIN:
                if (c == CH_CR) np = PH_NL3;
                else if (hs && (c == CH_SPACE || c == CH_TAB)) np = PH_LWS;
                else if (is_cntrl(c) || is_special(c)) st = ST_FAIL;
                else
                begin
                    np = PH_HNAME;
                    cls = CLS_HNAME;
                end
            PH_LWS:
                if (c == CH_CR)
                begin
                    np = PH_NL2;
                    tend = 1'b1;
                end
                else if (c == CH_SPACE || c == CH_TAB) ;
                else if (is_cntrl(c)) st = ST_FAIL;
                else
                begin
                    np = PH_HVALUE;
                    cls = CLS_HVALUE;
                    hs = 1'b1;
                end
            PH_HNAME:
                if (c == CH_COLON)
                begin
                    np = PH_SPACE_BEFORE_HV;
                    tend = 1'b1;
                end
                else if (is_cntrl(c) || is_special(c)) st = ST_FAIL;
                else cls = CLS_HNAME;
            PH_SPACE_BEFORE_HV:
                if (c == CH_SPACE) np = PH_HVALUE; else st = ST_FAIL;
            PH_HVALUE:
                if (c == CH_CR)
                begin
                    np = PH_NL2;
                    tend = 1'b1;
                end
                else if (is_cntrl(c)) st = ST_FAIL;
                else
                begin
                    cls = CLS_HVALUE;
                    hs = 1'b1;
                end
            PH_NL2:
                if (c == CH_LF) np = PH_LINE_BEGIN; else st = ST_FAIL;
            PH_NL3:
                st = (c == CH_LF) ? ST_DONE : ST_FAIL;
            default:
                st = ST_FAIL;
        endcase
        // a failing byte leaves every piece of state alone
        if (st == ST_FAIL)
        begin
            cls = CLS_NONE;
            tend = 1'b0;
        end
        else
        begin
            phase     = np;
            major_cnt = maj;
            minor_cnt = mnr;
            hdr_seen  = hs;
        end
        r = '{st, cls, tend, major_cnt, minor_cnt};
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_char(char_kind_t kind);
        logic [7:0] c;
        bit ok;
        do
        begin
            c = 8'($urandom_range(0, 255));
            case (kind)
                K_TOKEN:  ok = !is_cntrl(c) && !is_special(c);
                K_ALPHA:  ok = is_alpha(c);
                K_SCHEME: ok = is_alnum(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
                K_HOST:   ok = is_alnum(c) || c == CH_DOT || c == CH_MINUS;
                K_DIGIT:  ok = is_digit(c);
                K_PATH:   ok = !is_cntrl(c) && !is_space(c) && c != CH_QUEST;
                K_PARAM:  ok = !is_space(c) && c != CH_AMP && c != CH_EQUAL;
                default:  ok = !is_cntrl(c);
            endcase
        end
        while (!ok);
        return c;
    endfunction

    // result side: random stalls with calm stretches
    initial
    begin
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                rsp.ready <= 1'b0;
                hold--;
            end
            else if (calm > 0)
            begin
                rsp.ready <= 1'b1;
                calm--;
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                rsp.ready <= 1'b1;
                calm = $urandom_range(20, 150);
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                rsp.ready <= 1'b0;
                hold = pick_gap() - 1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // compare each result word, then predict for each accepted request word
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.byte_class !== want.byte_class)
                begin
                    $error("byte_class: expected %0d, got %0d", want.byte_class,
                           rsp.byte_class);
                    error_count++;
                end
                if (rsp.token_end !== want.token_end)
                begin
                    $error("token_end: expected %0d, got %0d", want.token_end,
                           rsp.token_end);
                    error_count++;
                end
                if (rsp.major_version !== want.major_version)
                begin
                    $error("major_version: expected %0d, got %0d", want.major_version,
                           rsp.major_version);
                    error_count++;
                end
                if (rsp.minor_version !== want.minor_version)
                begin
                    $error("minor_version: expected %0d, got %0d", want.minor_version,
                           rsp.minor_version);
                    error_count++;
                end
            end
        end
        if (req.valid && req.ready)
            pending_results.insert(pending_results.size(),
                                   predict_parse(req.op, req.data_byte));
    end

    // valid stays high from one word to the next unless a gap is drawn
    task automatic send_word(logic op, logic [7:0] b);
        int gap;
        gap = 0;
        if (src_calm > 0)
            src_calm--;
        else if ($urandom_range(0, 99) < 3)
            src_calm = $urandom_range(20, 80);
        else if ($urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.op        <= op;
        req.data_byte <= b;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_word(OP_DATA, s[i]);
    endtask

    task automatic test_request_line();
        send_word(OP_RESTART, 8'hff);
        send_text(" ");                 // a delimiter cannot open a method
        send_word(OP_DATA, 8'hff);      // high bytes are plain token bytes
        send_text("G\t7h+://[");        // digit before scheme holds, '[' at host start fails
        send_text("x-:80?k=");
        send_word(OP_DATA, 8'h00);
        send_text("&q ");
    endtask

    task automatic test_version_and_headers();
        send_text("HTTP/999.300\r\n");  // both versions clamp
        send_text("Ab: v\r\n\t w\r\n");  // continuation line after a value
        send_text("\r\n\nx");           // repeated newline completes again, other bytes fail
        send_word(OP_RESTART, 8'h00);
    endtask

    task automatic build_request(ref logic [7:0] msg[$]);
        bit slash;
        int ndig;
        slash = 1'b1;
        repeat ($urandom_range(1, 6)) append_byte(msg, rand_char(K_TOKEN));
        repeat ($urandom_range(1, 2))
            append_byte(msg, ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
        if ($urandom_range(0, 1) == 0)
            append_byte(msg, CH_SLASH);
        else
        begin
            if ($urandom_range(0, 3) == 0) append_byte(msg, rand_char(K_SCHEME));
            append_byte(msg, rand_char(K_ALPHA));
            repeat ($urandom_range(0, 4)) append_byte(msg, rand_char(K_SCHEME));
            append_byte(msg, CH_COLON);
            append_byte(msg, CH_SLASH);
            append_byte(msg, CH_SLASH);
            repeat ($urandom_range(0, 8)) append_byte(msg, rand_char(K_HOST));
            if ($urandom_range(0, 2) == 0)
            begin
                append_byte(msg, CH_COLON);
                repeat ($urandom_range(0, 5)) append_byte(msg, rand_char(K_DIGIT));
            end
            slash = ($urandom_range(0, 4) != 0);
            if (slash) append_byte(msg, CH_SLASH);
        end
        if (slash)
            repeat ($urandom_range(0, 8)) append_byte(msg, rand_char(K_PATH));
        if ($urandom_range(0, 9) < 4)
        begin
            append_byte(msg, CH_QUEST);
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(0, 4)) append_byte(msg, rand_char(K_PARAM));
                if ($urandom_range(0, 2) != 0)
                begin
                    append_byte(msg, CH_EQUAL);
                    repeat ($urandom_range(0, 4)) append_byte(msg, rand_char(K_PARAM));
                end
                append_byte(msg, CH_AMP);
            end
            void'(msg.pop_back());
        end
        append_byte(msg, CH_SPACE);
        append_byte(msg, CH_UP_H);
        append_byte(msg, CH_UP_T);
        append_byte(msg, CH_UP_T);
        append_byte(msg, CH_UP_P);
        append_byte(msg, CH_SLASH);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 4) : 1;
        repeat (ndig) append_byte(msg, rand_char(K_DIGIT));
        append_byte(msg, CH_DOT);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 4) : 1;
        repeat (ndig) append_byte(msg, rand_char(K_DIGIT));
        append_byte(msg, CH_CR);
        append_byte(msg, CH_LF);
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(1, 6)) append_byte(msg, rand_char(K_TOKEN));
            append_byte(msg, CH_COLON);
            append_byte(msg, CH_SPACE);
            repeat ($urandom_range(0, 8)) append_byte(msg, rand_char(K_TEXT));
            append_byte(msg, CH_CR);
            append_byte(msg, CH_LF);
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 2))
                    append_byte(msg, ($urandom_range(0, 1) == 0) ? CH_TAB : CH_SPACE);
                repeat ($urandom_range(0, 5)) append_byte(msg, rand_char(K_TEXT));
                append_byte(msg, CH_CR);
                append_byte(msg, CH_LF);
            end
        end
        append_byte(msg, CH_CR);
        append_byte(msg, CH_LF);
        if ($urandom_range(0, 9) < 3) append_byte(msg, CH_LF);
        if ($urandom_range(0, 9) == 0) append_byte(msg, 8'($urandom));
    endtask

    task automatic test_random_requests();
        logic [7:0] msg[$];
        int first;
        int cut;
        first = words_sent;
        while (words_sent - first < 800)
        begin
            msg.delete();
            send_word(OP_RESTART, 8'($urandom));
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 8)) append_byte(msg, 8'($urandom));
            else
            begin
                build_request(msg);
                if ($urandom_range(0, 6) == 0)
                    msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
                if ($urandom_range(0, 9) == 0)
                begin
                    cut = $urandom_range(1, msg.size());
                    while (msg.size() > cut) void'(msg.pop_back());
                end
            end
            foreach (msg[i])
            begin
                if ($urandom_range(0, 99) == 0) send_word(OP_RESTART, 8'($urandom));
                send_word(OP_DATA, msg[i]);
            end
        end
    endtask

    initial
    begin
        req.valid     <= 1'b0;
        req.op        <= OP_DATA;
        req.data_byte <= '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_request_line();
        test_version_and_headers();
        test_random_requests();
        req.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("** http_request_byte_parser: PASSED **");
        else
            $display("** http_request_byte_parser: FAILED **");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("** http_request_byte_parser: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/hrbp_pkg.sv
rtl/hrbp_if.sv
rtl/hrbp_front.sv
rtl/hrbp_queue.sv
rtl/hrbp_back.sv
rtl/http_request_byte_parser.sv
rtl/hrbp_checker.sv
tb/http_request_byte_parser_tb.sv
